// File: sv/scrc_pkg.sv
// package for the staggered cube range cover: widths, register indexes, stage payloads
package scrc_pkg;

  // largest domain height and derived widths
  localparam int MaxHeight = 16;
  localparam int LvlN      = MaxHeight + 1;
  localparam int CoordW    = 17;
  localparam int InW       = 18;
  localparam int HeightW   = 5;
  localparam int CfgIdxW   = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDomainHeight  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStaggeredMode = 2'd1;

  typedef logic [CoordW-1:0] coord_t;
  typedef coord_t [2:0]      vec3_t;

  // after clamp and widen
  typedef struct packed {
    vec3_t               lo;
    vec3_t               hi;
    logic [HeightW-1:0]  h;
    logic                mode;
  } st1_t;

  // after longest side
  typedef struct packed {
    vec3_t               lo;
    vec3_t               hi;
    coord_t              len;
    logic [HeightW-1:0]  h;
    logic                mode;
  } st2_t;

  // after per-level fit tests
  typedef struct packed {
    vec3_t                  lo;
    vec3_t                  hi;
    logic [LvlN-1:0]        lvl_ok;
    logic [LvlN-1:0][2:0]   sel;
    logic [HeightW-1:0]     h;
    logic                   mode;
  } st3_t;

  // after first-fit pick
  typedef struct packed {
    vec3_t               lo;
    vec3_t               hi;
    logic                found;
    logic [HeightW-1:0]  lvl;
    logic [2:0]          sel;
    logic [HeightW-1:0]  h;
    logic                mode;
  } st4_t;

  // result beat
  typedef struct packed {
    vec3_t               c;
    logic [HeightW-1:0]  size;
  } st5_t;

endpackage

// File: sv/staggered_cube_range_cover.sv
// staggered cube range cover: five-stage pipeline returning the smallest covering cube
//
// input channel: one beat per query box (inclusive start, exclusive end on x, y, z),
// taken when in_valid_i and in_ready_o are both high. output channel: one beat per
// query with the cube start corner and log2 of its side, taken when out_valid_o and
// out_ready_i are both high. results leave in the order the queries came in.
// pipeline: an accepted query passes one register per stage (clamp, longest side,
// parallel fit test of all 17 sizes, first-fit pick, corner) before it shows on the output.
// throughput: one query per cycle while the output is not stalled; every size level is
// tested side by side in stage three, so nothing iterates.
// configuration: cfg_we_i writes register cfg_idx_i (0 domain height, 1 staggered
// mode) with cfg_data_i; write only while the pipeline is empty.
// reset: all stages empty, domain height 16, staggered mode on.
// stall: each stage holds its beat while the stage after it is full and stalled;
// empty stages still fill, so the input keeps taking beats until the pipe is full.
module staggered_cube_range_cover import scrc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [HeightW-1:0]        cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [InW-1:0]     query_lo_x_i,
  input  logic signed [InW-1:0]     query_lo_y_i,
  input  logic signed [InW-1:0]     query_lo_z_i,
  input  logic signed [InW-1:0]     query_hi_x_i,
  input  logic signed [InW-1:0]     query_hi_y_i,
  input  logic signed [InW-1:0]     query_hi_z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [CoordW-1:0]         cover_x_o,
  output logic [CoordW-1:0]         cover_y_o,
  output logic [CoordW-1:0]         cover_z_o,
  output logic [HeightW-1:0]        cover_size_log2_o
);

  logic [HeightW-1:0] height_q;
  logic               mode_q;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic r1, r2, r3, r4, r5;
  st1_t s1_d, s1_q;
  st2_t s2_d, s2_q;
  st3_t s3_d, s3_q;
  st4_t s4_d, s4_q;
  st5_t s5_d, s5_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= HeightW'(MaxHeight);
      mode_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDomainHeight:  height_q <= cfg_data_i;
        CfgStaggeredMode: mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // per-stage ready chain
  assign r5 = !v5_q || out_ready_i;
  assign r4 = !v4_q || r5;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  // stage 1: saturate height, clamp box to domain, widen empty axes
  always_comb begin
    logic signed [InW-1:0] qlo [3];
    logic signed [InW-1:0] qhi [3];
    logic [HeightW-1:0]    h;
    coord_t                d;
    coord_t                l, u;
    qlo[0] = query_lo_x_i;
    qlo[1] = query_lo_y_i;
    qlo[2] = query_lo_z_i;
    qhi[0] = query_hi_x_i;
    qhi[1] = query_hi_y_i;
    qhi[2] = query_hi_z_i;
    h = (height_q > HeightW'(MaxHeight)) ? HeightW'(MaxHeight) : height_q;
    d = coord_t'(1) << h;
    s1_d = '0;
    for (int a = 0; a < 3; a++) begin
      if (qlo[a][InW-1])               l = '0;
      else if (qlo[a][CoordW-1:0] > d) l = d;
      else                             l = qlo[a][CoordW-1:0];
      if (qhi[a][InW-1])               u = '0;
      else if (qhi[a][CoordW-1:0] > d) u = d;
      else                             u = qhi[a][CoordW-1:0];
      if (u == l && u < d) u = u + coord_t'(1);
      s1_d.lo[a] = l;
      s1_d.hi[a] = u;
    end
    s1_d.h    = h;
    s1_d.mode = mode_q;
  end

  // stage 2: longest side, at least one
  always_comb begin
    logic signed [InW-1:0] diff;
    logic signed [InW-1:0] best;
    best = InW'(1);
    for (int a = 0; a < 3; a++) begin
      diff = $signed({1'b0, s1_q.hi[a]}) - $signed({1'b0, s1_q.lo[a]});
      if (diff > best) best = diff;
    end
    s2_d.lo   = s1_q.lo;
    s2_d.hi   = s1_q.hi;
    s2_d.len  = best[CoordW-1:0];
    s2_d.h    = s1_q.h;
    s2_d.mode = s1_q.mode;
  end

  // stage 3: fit test of every size level in parallel
  always_comb begin
    logic signed [InW:0] pk, mp, mh, d19, lo19, hi19, sp, lp, hm1, u, ur;
    logic                okl, okr, okp;
    logic [2:0]          fa, sa;
    d19 = $signed((InW+1)'(1) << s2_q.h);
    s3_d.lo   = s2_q.lo;
    s3_d.hi   = s2_q.hi;
    s3_d.h    = s2_q.h;
    s3_d.mode = s2_q.mode;
    s3_d.lvl_ok = '0;
    s3_d.sel    = '0;
    for (int k = 0; k < LvlN; k++) begin
      pk = $signed((InW+1)'(1) << k);
      mp = pk - 19'sd1;
      mh = (pk >>> 1) - 19'sd1;
      fa = '0;
      sa = '0;
      for (int a = 0; a < 3; a++) begin
        lo19 = $signed({2'b00, s2_q.lo[a]});
        hi19 = $signed({2'b00, s2_q.hi[a]});
        // aligned to own size
        sp  = (lo19 & ~mp) + pk;
        okp = hi19 <= sp;
        // left start, aligned to half size
        lp  = (lo19 & ~mh) + pk;
        okl = (lp <= d19) && (hi19 <= lp);
        // right start: end minus one rounded up to half size, minus size
        hm1 = hi19 - 19'sd1;
        u   = (hm1 + mh) & ~mh;
        ur  = u - pk;
        okr = (ur >= 19'sd0) && (u <= d19) && (ur <= lo19) && (hi19 <= u);
        if (!s2_q.mode) begin
          fa[a] = okp;
        end else if (k == 0) begin
          fa[a] = 1'b1;
        end else begin
          fa[a] = okl || okr;
          sa[a] = !okl;
        end
      end
      s3_d.lvl_ok[k] = (s2_q.len <= pk[CoordW-1:0] || k == MaxHeight)
                       && (s2_q.len <= pk[CoordW-1:0])
                       && (HeightW'(k) <= s2_q.h) && (&fa);
      s3_d.sel[k] = sa;
    end
  end

  // stage 4: first fitting level
  always_comb begin
    s4_d.lo    = s3_q.lo;
    s4_d.hi    = s3_q.hi;
    s4_d.h     = s3_q.h;
    s4_d.mode  = s3_q.mode;
    s4_d.found = 1'b0;
    s4_d.lvl   = '0;
    s4_d.sel   = '0;
    for (int k = LvlN - 1; k >= 0; k--) begin
      if (s3_q.lvl_ok[k]) begin
        s4_d.found = 1'b1;
        s4_d.lvl   = HeightW'(k);
        s4_d.sel   = s3_q.sel[k];
      end
    end
  end

  // stage 5: corner of the chosen cube
  always_comb begin
    logic signed [InW:0] pk, mp, mh, dm1, lo19, hi19, u, c;
    pk  = $signed((InW+1)'(1) << s4_q.lvl);
    mp  = pk - 19'sd1;
    mh  = (pk >>> 1) - 19'sd1;
    dm1 = $signed((InW+1)'(1) << s4_q.h) - 19'sd1;
    s5_d.c    = '0;
    s5_d.size = s4_q.lvl;
    for (int a = 0; a < 3; a++) begin
      lo19 = $signed({2'b00, s4_q.lo[a]});
      hi19 = $signed({2'b00, s4_q.hi[a]});
      u    = ((hi19 - 19'sd1) + mh) & ~mh;
      if (!s4_q.mode)           c = lo19 & ~mp;
      else if (s4_q.lvl == '0)  c = (lo19 > dm1) ? dm1 : lo19;
      else if (!s4_q.sel[a])    c = lo19 & ~mh;
      else                      c = u - pk;
      s5_d.c[a] = c[CoordW-1:0];
    end
    // nothing fits: whole domain
    if (!s4_q.found) begin
      s5_d.c    = '0;
      s5_d.size = s4_q.h;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (r5) v5_q <= v4_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (r1) s1_q <= s1_d;
    if (r2) s2_q <= s2_d;
    if (r3) s3_q <= s3_d;
    if (r4) s4_q <= s4_d;
    if (r5) s5_q <= s5_d;
  end

  assign out_valid_o       = v5_q;
  assign cover_x_o         = s5_q.c[0];
  assign cover_y_o         = s5_q.c[1];
  assign cover_z_o         = s5_q.c[2];
  assign cover_size_log2_o = s5_q.size;

endmodule
